@@ src/mmhl_pkg.sv @@
// Shared types and constants of the multi-class margin hinge loss core.
// No dependencies; every other file of the core except mmhl_if imports this package.
`default_nettype none
package mmhl_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_NUM_CLASSES   = 3'd0;
    localparam logic [2:0] REG_MARGIN        = 3'd1;
    localparam logic [2:0] REG_POWER_SELECT  = 3'd2;
    localparam logic [2:0] REG_REDUCTION     = 3'd3;
    localparam logic [2:0] REG_WEIGHT_ENABLE = 3'd4;

    // Input commands
    localparam logic CMD_SCORE  = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    // Reduction modes; the unused code behaves as a sum
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_MEAN = 2'd1;
    localparam logic [1:0] MODE_SUM  = 2'd2;

    localparam logic [1:0] POWER_LINEAR  = 2'd1;
    localparam logic [1:0] POWER_SQUARED = 2'd2;

    // Reset values of the registers
    localparam logic [6:0]        RST_NUM_CLASSES = 7'd2;
    localparam logic signed [15:0] RST_MARGIN     = 16'sd256;

    localparam logic [39:0]        LOSS_MAX   = 40'hFF_FFFF_FFFF;
    localparam logic signed [64:0] ACC_LIM    = 65'sh0_4000_0000_0000_0000;
    localparam logic [69:0]        MAG_LIM    = 70'h0_4000_0000_0000_0000;
    localparam int                 DIV_STEPS  = 64;
    localparam int                 QDEPTH     = 4;
    localparam int                 QPTR_W     = 2;

    typedef struct packed {
        logic [6:0]        num_classes;
        logic signed [15:0] margin;
        logic [1:0]        power_select;
        logic [1:0]        reduction_mode;
        logic              weight_enable;
    } cfg_t;

    // One classified input item, as queued between front and back
    typedef struct packed {
        logic        cmd;
        logic [15:0] value;
        logic [5:0]  index;      // weight entry, or the row target
        logic [6:0]  slot;       // score position in the row
        logic [6:0]  ncls;       // effective class count for this item
        logic        row_end;
        logic        last;
    } entry_t;

endpackage
`default_nettype wire

@@ src/mmhl_if.sv @@
// Channel interfaces of the hinge loss core: item input, result output, register writes.
// Depends on nothing; field widths are fixed by the item formats.
`default_nettype none
interface mmhl_in_if;
    logic              valid;
    logic              ready;
    logic              command;
    logic signed [15:0] value;
    logic [5:0]        class_index;
    logic              last_in_batch;

    modport source (output valid, command, value, class_index, last_in_batch, input ready);
    modport sink   (input valid, command, value, class_index, last_in_batch, output ready);
endinterface

interface mmhl_out_if;
    logic        valid;
    logic        ready;
    logic [39:0] loss;
    logic        is_batch_total;
    logic        target_error;

    modport source (output valid, loss, is_batch_total, target_error, input ready);
    modport sink   (input valid, loss, is_batch_total, target_error, output ready);
endinterface

interface mmhl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [15:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

@@ src/mmhl_front.sv @@
// Front part: accepts items, tracks the row position and tags row ends.
// Depends on mmhl_pkg and mmhl_if; feeds mmhl_fifo.
`default_nettype none
module mmhl_front #(
    parameter int MAX_CLASSES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    mmhl_in_if.sink          items,
    input  logic [6:0]       num_classes,
    input  logic             full,
    output logic             push,
    output mmhl_pkg::entry_t entry
);
    import mmhl_pkg::*;

    logic [6:0] cnt_reg;
    logic [5:0] tgt_reg;
    logic [6:0] n_eff;
    logic [5:0] tgt;
    logic       is_score;
    logic       row_end;

    always_comb
    begin
        if (num_classes == 7'd0)
            n_eff = 7'd1;
        else if (int'(num_classes) > MAX_CLASSES)
            n_eff = 7'(MAX_CLASSES);
        else
            n_eff = num_classes;
        is_score = (items.command == CMD_SCORE);
        tgt      = (cnt_reg == 7'd0) ? items.class_index : tgt_reg;
        row_end  = ({1'b0, cnt_reg} + 8'd1) >= {1'b0, n_eff};

        entry.cmd     = items.command;
        entry.value   = items.value;
        entry.index   = is_score ? tgt : items.class_index;
        entry.slot    = cnt_reg;
        entry.ncls    = n_eff;
        entry.row_end = is_score && row_end;
        entry.last    = items.last_in_batch;
    end

    assign items.ready = !full;
    assign push        = items.valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 7'd0;
            tgt_reg <= 6'd0;
        end
        else if (push && is_score)
        begin
            cnt_reg <= row_end ? 7'd0 : cnt_reg + 7'd1;
            tgt_reg <= tgt;
        end
    end

endmodule
`default_nettype wire

@@ src/mmhl_fifo.sv @@
// Short queue of classified items between the front and back parts.
// Depends on mmhl_pkg.
`default_nettype none
module mmhl_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mmhl_pkg::entry_t entry_in,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output mmhl_pkg::entry_t entry_out
);
    import mmhl_pkg::*;

    entry_t            slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full      = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign valid     = (cnt_reg != '0);
    assign entry_out = slots_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_reg] <= entry_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ src/mmhl_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on mmhl_pkg; shared by the row division and the batch mean.
`default_nettype none
module mmhl_div #(
    parameter int DW = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [63:0]   quotient
);
    import mmhl_pkg::*;

    logic          busy_reg;
    logic          done_reg;
    logic [5:0]    step_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dsr_reg;
    logic [63:0]   q_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial    = {rem_reg, q_reg[63]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign ge       = trial >= {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ src/mmhl_back.sv @@
// Back part: stores scores and weights, walks a finished row through the
// hinge pipeline, divides, reduces over the batch and drives the result.
// Depends on mmhl_pkg, mmhl_if and mmhl_div.
`default_nettype none
module mmhl_back #(
    parameter int MAX_CLASSES = 64,
    parameter int MAX_BATCH   = 65536,
    parameter int SCORE_BITS  = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mmhl_pkg::cfg_t   cfg,
    input  logic             q_valid,
    input  mmhl_pkg::entry_t q_entry,
    output logic             q_pop,
    mmhl_out_if.source       results
);
    import mmhl_pkg::*;

    localparam int IDXW = $clog2(MAX_CLASSES);
    localparam int CW   = $clog2(MAX_BATCH + 1);
    localparam int DW   = (CW > 7) ? CW : 7;
    localparam int HW   = ((SCORE_BITS > 16) ? SCORE_BITS : 16) + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TGT   = 4'd1;
    localparam logic [3:0] S_TGT2  = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_DRAIN = 4'd4;
    localparam logic [3:0] S_RWAIT = 4'd5;
    localparam logic [3:0] S_BATCH = 4'd6;
    localparam logic [3:0] S_MWAIT = 4'd7;
    localparam logic [3:0] S_MOUT  = 4'd8;

    logic [3:0] state_reg;

    logic signed [SCORE_BITS-1:0] score_mem [MAX_CLASSES];
    logic signed [15:0]           weight_mem [MAX_CLASSES];
    logic signed [SCORE_BITS-1:0] sc_rd_reg;
    logic signed [15:0]           wt_rd_reg;
    logic [IDXW-1:0]              sc_addr;
    logic [31:0]                  value_z;

    logic [6:0] row_n_reg;
    logic [5:0] row_tgt_reg;
    logic       row_last_reg;
    logic       row_err_reg;
    logic [6:0] d_reg;

    logic signed [SCORE_BITS-1:0] xt_reg;
    logic signed [15:0]           w_reg;

    // hinge pipeline
    logic              va_reg, skipa_reg;
    logic              vb_reg;
    logic [30:0]       hb_reg;
    logic              vc_reg;
    logic [61:0]       mc_reg;
    logic              vd_reg;
    logic [62:0]       magd_reg;
    logic signed [64:0] acc_reg;

    logic signed [HW-1:0] h_b;
    logic signed [63:0]   h64;
    logic [30:0]          h_cl;
    logic [61:0]          m_c;
    logic [15:0]          w_abs;
    logic [77:0]          prod_d;
    logic [62:0]          mag_d;
    logic signed [64:0]   acc_sum;
    logic signed [64:0]   acc_next;
    logic                 pipe_busy;

    logic [63:0]   row_loss_reg;
    logic [63:0]   bacc_reg;
    logic [CW-1:0] bcnt_reg;
    logic          berr_reg;
    logic [63:0]   row_loss_eff;
    logic [64:0]   bacc_sum;
    logic [63:0]   bacc_next;
    logic [CW-1:0] bcnt_next;
    logic          berr_next;

    logic [63:0] res_loss_reg;
    logic        res_total_reg;
    logic        res_err_reg;

    logic        out_valid_reg;
    logic [39:0] out_loss_reg;
    logic        out_total_reg;
    logic        out_err_reg;
    logic        out_free;

    logic          div_start;
    logic [63:0]   div_dividend;
    logic [DW-1:0] div_divisor;
    logic          div_done;
    logic [63:0]   div_quot;

    mmhl_div #(.DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign value_z   = 32'(q_entry.value);
    assign sc_addr   = (state_reg == S_WALK) ? IDXW'(d_reg) : IDXW'(row_tgt_reg);
    assign pipe_busy = va_reg || vb_reg || vc_reg || vd_reg;
    assign out_free  = !out_valid_reg || results.ready;

    // Memories: one write port each, registered reads
    always_ff @(posedge clk)
    begin
        if (q_pop && q_entry.cmd == CMD_SCORE)
            score_mem[IDXW'(q_entry.slot)] <= value_z[SCORE_BITS-1:0];
        if (q_pop && q_entry.cmd == CMD_WEIGHT && int'(q_entry.index) < MAX_CLASSES)
            weight_mem[IDXW'(q_entry.index)] <= q_entry.value;
        sc_rd_reg <= score_mem[sc_addr];
        wt_rd_reg <= weight_mem[IDXW'(row_tgt_reg)];
    end

    // Hinge datapath
    always_comb
    begin
        h_b  = HW'(cfg.margin) + HW'(sc_rd_reg) - HW'(xt_reg);
        h64  = 64'(h_b);
        h_cl = (h64 > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : h64[30:0];

        if (cfg.power_select == POWER_SQUARED)
            m_c = hb_reg * hb_reg;
        else
            m_c = {23'd0, hb_reg, 8'd0};

        w_abs  = w_reg[15] ? 16'(-w_reg) : 16'(w_reg);
        prod_d = mc_reg * w_abs;
        if (!cfg.weight_enable)
            mag_d = {1'b0, mc_reg};
        else if (prod_d[77:8] > MAG_LIM)
            mag_d = MAG_LIM[62:0];
        else
            mag_d = prod_d[70:8];

        if (cfg.weight_enable && w_reg[15])
            acc_sum = acc_reg - signed'(65'(magd_reg));
        else
            acc_sum = acc_reg + signed'(65'(magd_reg));
        if (acc_sum > ACC_LIM)
            acc_next = ACC_LIM;
        else if (acc_sum < -ACC_LIM)
            acc_next = -ACC_LIM;
        else
            acc_next = acc_sum;
    end

    always_ff @(posedge clk)
    begin
        skipa_reg <= (d_reg == {1'b0, row_tgt_reg});
        hb_reg    <= h_cl;
        mc_reg    <= m_c;
        magd_reg  <= mag_d;
        if (state_reg == S_TGT2)
        begin
            xt_reg <= sc_rd_reg;
            w_reg  <= wt_rd_reg;
        end
    end

    // Batch reduction
    always_comb
    begin
        row_loss_eff = row_err_reg ? 64'd0 : row_loss_reg;
        bacc_sum     = {1'b0, bacc_reg} + {1'b0, row_loss_eff};
        bacc_next    = bacc_sum[64] ? '1 : bacc_sum[63:0];
        bcnt_next    = (bcnt_reg < CW'(MAX_BATCH)) ? bcnt_reg + 1'b1 : bcnt_reg;
        berr_next    = berr_reg || row_err_reg;

        div_start    = 1'b0;
        div_dividend = acc_reg[64] ? 64'd0 : acc_reg[63:0];
        div_divisor  = DW'(row_n_reg);
        if (state_reg == S_DRAIN && !pipe_busy)
            div_start = 1'b1;
        if (state_reg == S_BATCH && cfg.reduction_mode == MODE_MEAN && row_last_reg)
        begin
            div_start    = 1'b1;
            div_dividend = bacc_next;
            div_divisor  = DW'(bcnt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_n_reg     <= 7'd1;
            row_tgt_reg   <= '0;
            row_last_reg  <= 1'b0;
            row_err_reg   <= 1'b0;
            d_reg         <= '0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            acc_reg       <= '0;
            row_loss_reg  <= '0;
            bacc_reg      <= '0;
            bcnt_reg      <= '0;
            berr_reg      <= 1'b0;
            res_loss_reg  <= '0;
            res_total_reg <= 1'b0;
            res_err_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_loss_reg  <= '0;
            out_total_reg <= 1'b0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            va_reg <= (state_reg == S_WALK);
            vb_reg <= va_reg && !skipa_reg && (h64 > 64'sd0);
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            if (vd_reg)
                acc_reg <= acc_next;

            // in S_MOUT the case below reloads the output register instead
            if (out_valid_reg && results.ready && state_reg != S_MOUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && q_entry.cmd == CMD_SCORE && q_entry.row_end)
                    begin
                        row_n_reg    <= q_entry.ncls;
                        row_tgt_reg  <= q_entry.index;
                        row_last_reg <= q_entry.last;
                        row_err_reg  <= {1'b0, q_entry.index} >= q_entry.ncls;
                        row_loss_reg <= '0;
                        if ({1'b0, q_entry.index} >= q_entry.ncls)
                            state_reg <= S_BATCH;
                        else
                            state_reg <= S_TGT;
                    end
                end
                S_TGT:
                begin
                    acc_reg   <= '0;
                    state_reg <= S_TGT2;
                end
                S_TGT2:
                begin
                    d_reg     <= '0;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    d_reg <= d_reg + 7'd1;
                    if (d_reg == row_n_reg - 7'd1)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (!pipe_busy)
                        state_reg <= S_RWAIT;
                end
                S_RWAIT:
                begin
                    if (div_done)
                    begin
                        row_loss_reg <= div_quot;
                        state_reg    <= S_BATCH;
                    end
                end
                S_BATCH:
                begin
                    if (cfg.reduction_mode == MODE_NONE)
                    begin
                        res_loss_reg  <= row_loss_eff;
                        res_total_reg <= 1'b0;
                        res_err_reg   <= row_err_reg;
                        bacc_reg      <= row_last_reg ? '0 : bacc_next;
                        bcnt_reg      <= row_last_reg ? '0 : bcnt_next;
                        berr_reg      <= row_last_reg ? 1'b0 : berr_next;
                        state_reg     <= S_MOUT;
                    end
                    else if (!row_last_reg)
                    begin
                        bacc_reg  <= bacc_next;
                        bcnt_reg  <= bcnt_next;
                        berr_reg  <= berr_next;
                        state_reg <= S_IDLE;
                    end
                    else if (cfg.reduction_mode == MODE_MEAN)
                    begin
                        bacc_reg  <= bacc_next;
                        bcnt_reg  <= bcnt_next;
                        berr_reg  <= berr_next;
                        state_reg <= S_MWAIT;
                    end
                    else
                    begin
                        res_loss_reg  <= bacc_next;
                        res_total_reg <= 1'b1;
                        res_err_reg   <= berr_next;
                        bacc_reg      <= '0;
                        bcnt_reg      <= '0;
                        berr_reg      <= 1'b0;
                        state_reg     <= S_MOUT;
                    end
                end
                S_MWAIT:
                begin
                    if (div_done)
                    begin
                        res_loss_reg  <= div_quot;
                        res_total_reg <= 1'b1;
                        res_err_reg   <= berr_reg;
                        bacc_reg      <= '0;
                        bcnt_reg      <= '0;
                        berr_reg      <= 1'b0;
                        state_reg     <= S_MOUT;
                    end
                end
                S_MOUT:
                begin
                    // hold until the output register can take the result
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_loss_reg  <= (|res_loss_reg[63:40]) ? LOSS_MAX
                                                                : res_loss_reg[39:0];
                        out_total_reg <= res_total_reg;
                        out_err_reg   <= res_err_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.loss           = out_loss_reg;
    assign results.is_batch_total = out_total_reg;
    assign results.target_error   = out_err_reg;

    a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pipe_busy)
        else $error("hinge pipeline busy while idle");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_RWAIT || state_reg == S_MWAIT))
        else $error("divider finished outside a wait state");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg <= ACC_LIM) && (acc_reg >= -ACC_LIM))
        else $error("row accumulator out of range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bcnt_reg <= CW'(MAX_BATCH))
        else $error("row count above limit");

endmodule
`default_nettype wire

@@ src/multi_margin_hinge_loss_core.sv @@
// Top level of the multi-class margin hinge loss core: registers, front, queue, back.
// Depends on mmhl_pkg, mmhl_if, mmhl_front, mmhl_fifo, mmhl_back.
//
//  channel  | role   | transfer
//  items    | sink   | score element or class weight write
//  results  | source | row loss or batch total, Q24.16
//  cfg      | sink   | register write, always ready
//
// The back end pops score and weight items while idle; the front queues up to four.
// A completed row goes through the hinge walk and then the bit-serial divider;
// a batch mean uses the same divider once more.
// Reset clears the row position, batch totals and output; stores are not cleared.
// A stalled result holds the back end once its output register is full.
`default_nettype none
module multi_margin_hinge_loss_core #(
    parameter int MAX_CLASSES = 64,
    parameter int MAX_BATCH   = 65536,
    parameter int SCORE_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mmhl_in_if.sink    items,
    mmhl_out_if.source results,
    mmhl_cfg_if.sink   cfg
);
    import mmhl_pkg::*;

    cfg_t   cfg_reg;
    logic   push;
    logic   full;
    entry_t f_entry;
    logic   q_valid;
    logic   q_pop;
    entry_t q_entry;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_classes    <= RST_NUM_CLASSES;
            cfg_reg.margin         <= RST_MARGIN;
            cfg_reg.power_select   <= POWER_LINEAR;
            cfg_reg.reduction_mode <= MODE_MEAN;
            cfg_reg.weight_enable  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                REG_NUM_CLASSES:   cfg_reg.num_classes    <= cfg.data[6:0];
                REG_MARGIN:        cfg_reg.margin         <= cfg.data;
                REG_POWER_SELECT:  cfg_reg.power_select   <= cfg.data[1:0];
                REG_REDUCTION:     cfg_reg.reduction_mode <= cfg.data[1:0];
                REG_WEIGHT_ENABLE: cfg_reg.weight_enable  <= cfg.data[0];
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    mmhl_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .num_classes (cfg_reg.num_classes),
        .full        (full),
        .push        (push),
        .entry       (f_entry)
    );

    mmhl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (f_entry),
        .full      (full),
        .pop       (q_pop),
        .valid     (q_valid),
        .entry_out (q_entry)
    );

    mmhl_back #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_BATCH   (MAX_BATCH),
        .SCORE_BITS  (SCORE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .results (results)
    );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the multi-class margin hinge loss core: directed and random item streams.
// Uses mmhl_pkg and the mmhl_if channel interfaces. It predicts every row and batch loss
// and checks each result, field by field, in order.
`timescale 1ns / 1ps
module tb;
    import mmhl_pkg::*;

    typedef struct packed {
        logic [39:0] loss;
        logic        total;
        logic        err;
    } loss_rec_t;

    localparam logic [63:0] TERM_LIM = 64'h4000_0000_0000_0000;

    logic clk;
    logic rst_n;

    mmhl_in_if  items ();
    mmhl_out_if results ();
    mmhl_cfg_if cfg ();

    multi_margin_hinge_loss_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    // predictor state
    logic [6:0]  m_ncls;
    logic [15:0] m_margin;
    logic [1:0]  m_power;
    logic [1:0]  m_mode;
    logic        m_wen;
    longint      scores [64];
    longint      weights [64];
    int          elem_cnt;
    logic [5:0]  row_tgt;
    logic [63:0] batch_acc;
    int          batch_rows;
    bit          batch_err;

    loss_rec_t   expected_losses [$];
    int          fails;
    int          send_idle;
    int          recv_idle;
    int          hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] weighted_term(logic [63:0] m, logic [63:0] w);
        logic [63:0] r;
        if (w == 0)
            return 0;
        if ((m >> 8) > TERM_LIM / w)
            return TERM_LIM;
        r = (m >> 8) * w + (((m & 64'd255) * w) >> 8);
        return (r > TERM_LIM) ? TERM_LIM : r;
    endfunction

    function automatic int eff_classes();
        if (m_ncls == 0)
            return 1;
        return (m_ncls > 64) ? 64 : int'(m_ncls);
    endfunction

    function automatic logic [63:0] hinge_row_loss(int n);
        longint              xt;
        longint              mg;
        longint              w;
        longint              h;
        logic [63:0]         mag;
        logic signed [65:0]  acc;
        bit                  neg;
        xt  = scores[row_tgt];
        mg  = longint'($signed(m_margin));
        w   = weights[row_tgt];
        acc = 0;
        for (int d = 0; d < n; d++)
        begin
            neg = 1'b0;
            if (d == row_tgt)
                continue;
            h = mg + scores[d] - xt;
            if (h <= 0)
                continue;
            if (h > 64'sh7FFF_FFFF)
                h = 64'sh7FFF_FFFF;
            mag = (m_power == POWER_SQUARED) ? h * h : h << 8;
            if (m_wen)
            begin
                neg = w < 0;
                mag = weighted_term(mag, neg ? -w : w);
            end
            acc = neg ? acc - $signed({2'b00, mag}) : acc + $signed({2'b00, mag});
            if (acc > $signed({2'b00, TERM_LIM}))
                acc = $signed({2'b00, TERM_LIM});
            if (acc < -$signed({2'b00, TERM_LIM}))
                acc = -$signed({2'b00, TERM_LIM});
        end
        if (acc < 0)
            acc = 0;
        return acc[63:0] / n;
    endfunction

    function automatic logic [39:0] clip_loss(logic [63:0] x);
        return (x > LOSS_MAX) ? LOSS_MAX : x[39:0];
    endfunction

    function automatic void predict_item(logic cmd, logic [15:0] val, logic [5:0] idx,
                                         logic last);
        int          n;
        bit          err;
        logic [63:0] loss;
        logic [64:0] sum;
        if (cmd == CMD_WEIGHT)
        begin
            weights[idx] = longint'($signed(val));
            return;
        end
        n = eff_classes();
        if (elem_cnt == 0)
            row_tgt = idx;
        scores[elem_cnt] = longint'($signed(val));
        elem_cnt++;
        if (elem_cnt < n)
            return;
        elem_cnt = 0;
        err  = row_tgt >= n;
        loss = err ? 64'd0 : hinge_row_loss(n);
        sum  = {1'b0, batch_acc} + {1'b0, loss};
        batch_acc = sum[64] ? '1 : sum[63:0];
        if (batch_rows < 65536)
            batch_rows++;
        batch_err = batch_err | err;
        if (m_mode == MODE_NONE)
        begin
            expected_losses.push_back('{clip_loss(loss), 1'b0, err});
        end
        else
        begin
            if (!last)
                return;
            loss = batch_acc;
            if (m_mode == MODE_MEAN)
                loss = loss / batch_rows;
            expected_losses.push_back('{clip_loss(loss), 1'b1, batch_err});
        end
        if (last)
        begin
            batch_acc  = 0;
            batch_rows = 0;
            batch_err  = 1'b0;
        end
    endfunction

    // result checker
    initial
    begin
        loss_rec_t want;
        forever
        begin
            @(posedge clk);
            if (results.valid && results.ready)
            begin
                if (expected_losses.size() == 0)
                begin
                    $error("unexpected result: loss %0d", results.loss);
                    fails++;
                end
                else
                begin
                    want = expected_losses.pop_front();
                    if (results.loss !== want.loss)
                    begin
                        $error("loss: expected %0d, got %0d", want.loss, results.loss);
                        fails++;
                    end
                    if (results.is_batch_total !== want.total)
                    begin
                        $error("is_batch_total: expected %0b, got %0b", want.total,
                               results.is_batch_total);
                        fails++;
                    end
                    if (results.target_error !== want.err)
                    begin
                        $error("target_error: expected %0b, got %0b", want.err,
                               results.target_error);
                        fails++;
                    end
                end
            end
        end
    end

    // receiver: drive ready, with an optional long hold-off counted in cycles
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_item(logic cmd, logic [15:0] val, logic [5:0] idx, logic last);
        while ($urandom_range(99) < send_idle)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid         <= 1'b1;
        items.command       <= cmd;
        items.value         <= val;
        items.class_index   <= idx;
        items.last_in_batch <= last;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        predict_item(cmd, val, idx, last);
    endtask

    // wait out every expected result, then the back end's row and mean latency
    task automatic drain();
        items.valid <= 1'b0;
        @(posedge clk);
        while (expected_losses.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [15:0] data);
        cfg.valid <= 1'b1;
        cfg.addr  <= addr;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (addr)
            REG_NUM_CLASSES:   m_ncls   = data[6:0];
            REG_MARGIN:        m_margin = data;
            REG_POWER_SELECT:  m_power  = data[1:0];
            REG_REDUCTION:     m_mode   = data[1:0];
            REG_WEIGHT_ENABLE: m_wen    = data[0];
            default: ;
        endcase
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [6:0] n, logic [15:0] mg, logic [1:0] pw,
                              logic [1:0] md, logic we);
        write_reg(REG_NUM_CLASSES, {9'd0, n});
        write_reg(REG_MARGIN, mg);
        write_reg(REG_POWER_SELECT, {14'd0, pw});
        write_reg(REG_REDUCTION, {14'd0, md});
        write_reg(REG_WEIGHT_ENABLE, {15'd0, we});
    endtask

    // one row; wide spreads reach the extremes, narrow ones keep hinges near zero
    task automatic send_row(bit last, bit bad_tgt, bit wide);
        int          n;
        logic [5:0]  tgt;
        logic [15:0] base;
        logic [15:0] val;
        n    = eff_classes();
        tgt  = bad_tgt ? 6'($urandom_range(63)) : 6'($urandom_range(n - 1));
        base = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(CMD_WEIGHT, 16'($urandom), 6'($urandom), 1'($urandom));
            val = wide ? 16'($urandom) : base + 16'($urandom_range(1023)) - 16'd512;
            // last_in_batch on an inner element is noise and must be ignored
            send_item(CMD_SCORE, val, (i == 0) ? tgt : 6'($urandom),
                      (i == n - 1) ? last : ($urandom_range(7) == 0));
        end
    endtask

    task automatic test_reset_config();
        repeat (4) send_row(1'b0, 1'b0, 1'b1);
        send_row(1'b1, 1'b0, 1'b0);
        drain();
    endtask

    task automatic test_weight_load();
        for (int i = 0; i < 64; i++)
            send_item(CMD_WEIGHT, 16'($urandom_range(16'h7FFF, 16'h0080)), 6'(i), 1'b0);
        drain();
    endtask

    task automatic test_extremes();
        set_config(7'd3, 16'h7FFF, POWER_SQUARED, MODE_NONE, 1'b1);
        send_item(CMD_WEIGHT, 16'h8000, 6'd0, 1'b0);   // negative weight
        send_item(CMD_WEIGHT, 16'h7FFF, 6'd1, 1'b0);
        send_item(CMD_SCORE, 16'h8000, 6'd0, 1'b0);
        send_item(CMD_SCORE, 16'h7FFF, 6'd0, 1'b0);
        send_item(CMD_SCORE, 16'h7FFF, 6'd0, 1'b0);
        send_item(CMD_SCORE, 16'h8000, 6'd1, 1'b1);
        send_item(CMD_SCORE, 16'h7FFF, 6'd1, 1'b0);
        send_item(CMD_SCORE, 16'h7FFF, 6'd1, 1'b0);
        send_item(CMD_SCORE, 16'd0, 6'd63, 1'b0);      // target out of range
        send_item(CMD_SCORE, 16'd0, 6'd63, 1'b0);
        send_item(CMD_SCORE, 16'd0, 6'd63, 1'b1);
        drain();
        // class count zero acts as one; reduction code three acts as a sum
        set_config(7'd0, 16'h8000, POWER_LINEAR, 2'd3, 1'b0);
        send_item(CMD_SCORE, 16'h7FFF, 6'd0, 1'b0);
        send_item(CMD_SCORE, 16'h1234, 6'd1, 1'b1);
        drain();
        // class count above the maximum clamps to 64
        set_config(7'd127, 16'h7FFF, POWER_SQUARED, MODE_SUM, 1'b0);
        send_row(1'b0, 1'b0, 1'b1);
        send_row(1'b1, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        set_config(7'd2, 16'h0100, POWER_LINEAR, MODE_NONE, 1'b0);
        send_idle   = 0;
        recv_idle   = 0;
        hold_cycles = 800;
        repeat (30) send_row(1'b0, 1'b0, 1'b0);
        drain();
    endtask

    task automatic test_random(int s_idle, int r_idle, int n_items);
        int   sent;
        logic [6:0] n;
        send_idle = s_idle;
        recv_idle = r_idle;
        sent      = 0;
        while (sent < n_items)
        begin
            n = ($urandom_range(9) == 0) ? 7'd64 : 7'($urandom_range(8, 1));
            set_config(n, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048)),
                       2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom));
            repeat ($urandom_range(12, 3))
            begin
                send_row($urandom_range(3) == 0, $urandom_range(9) == 0,
                         $urandom_range(2) == 0);
                sent += eff_classes();
            end
            send_row(1'b1, 1'b0, 1'b0);
            sent += eff_classes();
            // pause the sender until everything has come back
            drain();
        end
    endtask

    initial
    begin
        items.valid         = 1'b0;
        items.command       = CMD_SCORE;
        items.value         = '0;
        items.class_index   = '0;
        items.last_in_batch = 1'b0;
        cfg.valid           = 1'b0;
        cfg.addr            = REG_NUM_CLASSES;
        cfg.data            = '0;
        results.ready       = 1'b0;
        m_ncls      = RST_NUM_CLASSES;
        m_margin    = RST_MARGIN;
        m_power     = POWER_LINEAR;
        m_mode      = MODE_MEAN;
        m_wen       = 1'b0;
        elem_cnt    = 0;
        row_tgt     = '0;
        batch_acc   = '0;
        batch_rows  = 0;
        batch_err   = 1'b0;
        fails       = 0;
        send_idle   = 0;
        recv_idle   = 0;
        hold_cycles = 0;
        rst_n       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_weight_load();
        test_extremes();
        test_backpressure();
        test_random(22, 80, 220);
        test_random(80, 22, 220);
        test_random(0, 0, 220);
        drain();

        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
src/mmhl_pkg.sv
src/mmhl_if.sv
src/mmhl_front.sv
src/mmhl_fifo.sv
src/mmhl_div.sv
src/mmhl_back.sv
src/multi_margin_hinge_loss_core.sv
sim/tb.sv
